// ===== hdl/gddn_pkg.sv =====
package gddn_pkg;

  // Field widths of one date beat and one result beat.
  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int ErrW    = 2;
  localparam int DoyW    = 9;
  localparam int SerialW = 22;
  localparam int WeekW   = 6;

  localparam int InDataW  = 24;
  localparam int OutDataW = 40;

  // Working widths inside the datapath.
  localparam int Q100W  = 8;
  localparam int Rem100W = 7;
  localparam int Fold7W = 6;

  // Calendar constants.
  localparam logic [YearW-1:0]  YearMax   = 14'd9999;
  localparam logic [MonthW-1:0] MonthMax  = 4'd12;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
  localparam logic [Rem100W-1:0] RemLast  = 7'd99;

  // Result codes.
  localparam logic [ErrW-1:0] ErrNone  = 2'd0;
  localparam logic [ErrW-1:0] ErrYear  = 2'd1;
  localparam logic [ErrW-1:0] ErrMonth = 2'd2;
  localparam logic [ErrW-1:0] ErrDay   = 2'd3;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic divide;
    logic calc;
    logic fold;
    logic finish;
  } gddn_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_free;
  } gddn_status_t;

  // Days in the months before the given month of a common year.
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Length of the given month; February follows the leap flag.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] v;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
      4'd2:    v = leap ? 5'd29 : 5'd28;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/gddn_ctrl.sv =====
module gddn_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gddn_pkg::gddn_status_t status,
  output gddn_pkg::gddn_cmd_t    cmd
);
  import gddn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIVIDE = 5'b00010,
    S_CALC   = 5'b00100,
    S_FOLD   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  // One date at a time walks through the datapath steps.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.divide = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // Wait here until the output register can take the result.
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/gddn_datapath.sv =====
module gddn_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  gddn_pkg::gddn_cmd_t          cmd,
  output gddn_pkg::gddn_status_t       status,
  input  logic [gddn_pkg::InDataW-1:0]  in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gddn_pkg::OutDataW-1:0] out_data
);
  import gddn_pkg::*;

  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [DayW-1:0]    day;
  logic [YearW-1:0]   r;
  logic [Q100W-1:0]   q100;
  logic [ErrW-1:0]    err;
  logic               leap;
  logic [DoyW-1:0]    doy;
  logic [SerialW-1:0] jan1;
  logic [SerialW-1:0] serial;
  logic [Fold7W-1:0]  fold7;

  logic [26:0]        q_prod;
  logic [Rem100W-1:0] rem100;
  logic               leap_c;
  logic [ErrW-1:0]    err_c;
  logic [DoyW-1:0]    doy_c;
  logic [23:0]        jan1_c;
  logic [23:0]        jan1_pad;
  logic [Fold7W-1:0]  fold_c;
  logic [3:0]         f2;
  logic [2:0]         wday;
  logic [9:0]         wx;
  logic [16:0]        wprod;
  logic [WeekW-1:0]   week;

  // Years before this one divided by 100: 5243 / 2^19 is exact over 14 bits.
  assign q_prod = {13'd0, r} * 27'd5243;

  // Leap test, errors, day of year and serial day of 1 January.
  always_comb begin
    rem100 = Rem100W'(r - YearW'({6'd0, q100} * 14'd100));
    leap_c = (r[1:0] == 2'd3) && ((rem100 != RemLast) || (q100[1:0] == 2'd3));
    if (year == '0 || year > YearMax) begin
      err_c = ErrYear;
    end else if (month == '0 || month > MonthMax) begin
      err_c = ErrMonth;
    end else if (day == '0 || day > month_len(month, leap_c)) begin
      err_c = ErrDay;
    end else begin
      err_c = ErrNone;
    end
    doy_c = days_before(month) + DoyW'(leap_c && month > MonthFeb)
            + DoyW'(day) - DoyW'(1);
    jan1_c = {10'd0, r} * 24'd365 + 24'(r >> 2) - 24'(q100) + 24'(q100 >> 2);
  end

  // Remainder by 7 through folding 3-bit groups, since 8 is 1 modulo 7.
  always_comb begin
    jan1_pad = {2'd0, jan1};
    fold_c   = '0;
    for (int i = 0; i < 8; i++) begin
      fold_c = fold_c + Fold7W'(jan1_pad[3*i +: 3]);
    end
  end

  // Week number: (weekday of 1 January + day of year) / 7 + 1.
  always_comb begin
    f2 = 4'(fold7[5:3]) + 4'(fold7[2:0]);
    if (f2 >= 4'd14) begin
      wday = 3'(f2 - 4'd14);
    end else if (f2 >= 4'd7) begin
      wday = 3'(f2 - 4'd7);
    end else begin
      wday = f2[2:0];
    end
    wx    = 10'(wday) + 10'(doy);
    wprod = {7'd0, wx} * 17'd293;
    week  = WeekW'(wprod[16:11]) + WeekW'(1);
  end

  // Working registers, each loaded by its own step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year  <= in_data[YearW-1:0];
      month <= in_data[YearW +: MonthW];
      day   <= in_data[YearW+MonthW +: DayW];
      r     <= in_data[YearW-1:0] - YearW'(1);
    end
    if (cmd.divide) begin
      q100 <= q_prod[26:19];
    end
    if (cmd.calc) begin
      err  <= err_c;
      leap <= leap_c;
      doy  <= doy_c;
      jan1 <= jan1_c[SerialW-1:0];
    end
    if (cmd.fold) begin
      fold7  <= fold_c;
      serial <= jan1 + SerialW'(doy);
    end
  end

  // Output register; all result fields but the error code are zero on error.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (err == ErrNone) begin
        out_data <= {week, serial, doy, leap, err};
      end else begin
        out_data <= {{(OutDataW-ErrW){1'b0}}, err};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== hdl/gregorian_date_to_day_number.sv =====
// Gregorian date to serial day number, one result beat per date beat.
// The date beat is registered by the load step; the divide, calc, fold and
// finish steps follow, and finish loads the result into the output register.
// One date at a time is taken; a stalled output holds the finish step.
// Reset: rst is synchronous, active high, and empties the block.
module gregorian_date_to_day_number (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year_in[13:0], month_in[17:14], day_in[22:18], zero pad [23]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // error_code[1:0], leap_year[2], day_of_year[11:3], serial_day[33:12],
  // week_of_year[39:34]
  output logic [39:0] m_axis_tdata
);
  import gddn_pkg::*;

  gddn_cmd_t    cmd;
  gddn_status_t status;

  gddn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gddn_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
